// File: rtl/cubic_bezier_flattener_macros.svh
// Assertion macros shared by the cubic Bezier flattener RTL.
`ifndef CUBIC_BEZIER_FLATTENER_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CBF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define CBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cbf_pkg.sv
// Types and constants of the cubic Bezier flattener.
package cbf_pkg;

  localparam int CoordBits = 10;
  localparam int CoefW     = CoordBits + 4;
  localparam int HW        = CoordBits + 24;
  localparam int TW        = 16;
  localparam int StepW     = 6;
  localparam int FracBits  = 16;

  localparam logic [StepW-1:0] StepCountRst = StepW'(20);
  localparam logic [TW-1:0]    TStepRst     = TW'(3277);
  localparam logic [TW-1:0]    TMax         = {TW{1'b1}};

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic {
    CFG_STEP_COUNT = 1'b0,
    CFG_T_STEP     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COEF,
    ST_MUL,
    ST_PUSH
  } state_e;

  typedef enum logic [1:0] {
    PH_H2,
    PH_H1,
    PH_H0,
    PH_RND
  } phase_e;

  typedef struct packed {
    logic signed [CoefW-1:0] c0;
    logic signed [CoefW-1:0] c1;
    logic signed [CoefW-1:0] c2;
    logic signed [CoefW-1:0] c3;
  } coef_t;

  typedef struct packed {
    logic in_ready;
    logic seg_start;
    logic push;
    logic mul_en;
  } ctrl_t;

endpackage

// File: rtl/cubic_bezier_flattener.sv
// Top level of the cubic Bezier flattener: sequencer and shared multiplier datapath.
//
// Control points enter on the input channel (valid/ready). An item with op set to
// clear empties the point chain. The first three points of a chain, and the
// middle two points of each later segment, are stored and give no result. The
// point that closes a segment starts a run: the block evaluates the cubic at
// step_count values of t and then returns the closing point itself with
// is_endpoint and last set. That point stays as the start of the next segment.
// One signed multiplier is shared by all Horner steps: each axis runs the
// multiply-accumulate phases H2, H1 and H0 and then a rounding phase, x before y,
// and the finished point is then loaded into the output register. The input is
// not ready during a run. Results leave through a single output register; while
// the receiver stalls, the sequencer holds the next finished point and waits.
// Reset empties the chain and sets step_count to 20 and t_step to 3277.
// Configuration writes take effect at once; the user must see that they are made
// only while the block is idle, as the block itself does not enforce this.
module cubic_bezier_flattener (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [cbf_pkg::TW-1:0]        cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [cbf_pkg::CoordBits-1:0] point_x_i,
  input  logic [cbf_pkg::CoordBits-1:0] point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cbf_pkg::CoordBits-1:0] out_x_o,
  output logic [cbf_pkg::CoordBits-1:0] out_y_o,
  output logic                          is_endpoint_o,
  output logic                          last_o
);
  import cbf_pkg::*;
  `include "cubic_bezier_flattener_macros.svh"

  localparam int PW = HW + TW + 1;
  localparam int RW = HW - FracBits;
  localparam logic signed [HW-1:0] HalfLsb = HW'(1) <<< (FracBits - 1);
  localparam logic signed [RW-1:0] CoordMax = RW'((1 << CoordBits) - 1);

  state_e                state_q, state_d;
  phase_e                phase_q;
  ctrl_t                 ctl;
  logic                  axis_q;
  logic                  end_q;
  logic [StepW-1:0]      k_q;
  logic [TW-1:0]         t_q;
  logic [StepW-1:0]      step_count_q;
  logic [TW-1:0]         t_step_q;
  logic [1:0]            fill_q;
  logic [CoordBits-1:0]  ctrl_x_q [3];
  logic [CoordBits-1:0]  ctrl_y_q [3];
  logic [CoordBits-1:0]  p3x_q, p3y_q;
  coef_t                 coef_q [2];
  logic signed [HW-1:0]  h_q, h_d;
  logic [CoordBits-1:0]  rx_q, ry_q;
  logic [CoordBits-1:0]  rnd_val;
  logic                  out_valid_q;
  logic [CoordBits-1:0]  out_x_q, out_y_q;
  logic                  out_end_q;
  logic                  slot_free;
  logic                  last_point;
  logic [TW:0]           t_sum;
  coef_t                 cur;
  logic signed [HW-1:0]  mul_a;
  logic signed [TW:0]    mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [HW-1:0]  rnd_sum;
  logic signed [RW-1:0]  rnd_q16;

  function automatic coef_t calc_coef(logic [CoordBits-1:0] p0, logic [CoordBits-1:0] p1,
                                      logic [CoordBits-1:0] p2, logic [CoordBits-1:0] p3);
    logic signed [CoefW-1:0] s0, s1, s2, s3, d10, d2, d12;
    coef_t c;
    s0  = $signed({4'b0000, p0});
    s1  = $signed({4'b0000, p1});
    s2  = $signed({4'b0000, p2});
    s3  = $signed({4'b0000, p3});
    d10 = s1 - s0;
    d2  = s0 - (s1 <<< 1) + s2;
    d12 = s1 - s2;
    c.c0 = s0;
    c.c1 = (d10 <<< 1) + d10;
    c.c2 = (d2 <<< 1) + d2;
    c.c3 = (s3 - s0) + (d12 <<< 1) + d12;
    return c;
  endfunction

  function automatic logic signed [HW-1:0] q16(logic signed [CoefW-1:0] c);
    return {{(HW - CoefW - FracBits){c[CoefW-1]}}, c, {FracBits{1'b0}}};
  endfunction

  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_point = (k_q + StepW'(1)) == step_count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctl.seg_start) begin
          state_d = ST_COEF;
        end
      end
      ST_COEF: begin
        state_d = (step_count_q == '0) ? ST_PUSH : ST_MUL;
      end
      ST_MUL: begin
        if (phase_q == PH_RND && axis_q) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          if (end_q) begin
            state_d = ST_IDLE;
          end else if (last_point) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.in_ready  = (state_q == ST_IDLE);
    ctl.seg_start = ctl.in_ready && in_valid_i && (op_e'(op_i) == OP_ADD) && (fill_q == 2'd3);
    ctl.push      = (state_q == ST_PUSH) && slot_free;
    ctl.mul_en    = (state_q == ST_MUL);
  end

  assign cur     = coef_q[axis_q];
  assign mul_a   = (phase_q == PH_H2) ? HW'(cur.c3) : h_q;
  assign mul_b   = $signed({1'b0, t_q});
  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign rnd_sum = h_q + HalfLsb;
  assign rnd_q16 = rnd_sum[HW-1:FracBits];
  assign t_sum   = {1'b0, t_q} + {1'b0, t_step_q};

  always_comb begin
    h_d = h_q;
    case (phase_q)
      PH_H2:   h_d = q16(cur.c2) + prod[HW-1:0];
      PH_H1:   h_d = q16(cur.c1) + prod[HW+FracBits-1:FracBits];
      PH_H0:   h_d = q16(cur.c0) + prod[HW+FracBits-1:FracBits];
      default: h_d = h_q;
    endcase
    if (rnd_q16 < 0) begin
      rnd_val = '0;
    end else if (rnd_q16 > CoordMax) begin
      rnd_val = {CoordBits{1'b1}};
    end else begin
      rnd_val = rnd_q16[CoordBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_H2;
      axis_q       <= 1'b0;
      end_q        <= 1'b0;
      k_q          <= '0;
      t_q          <= '0;
      step_count_q <= StepCountRst;
      t_step_q     <= TStepRst;
      fill_q       <= '0;
      ctrl_x_q     <= '{default: '0};
      ctrl_y_q     <= '{default: '0};
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_STEP_COUNT) begin
          step_count_q <= cfg_wdata_i[StepW-1:0];
        end else begin
          t_step_q <= cfg_wdata_i;
        end
      end
      if (ctl.in_ready && in_valid_i) begin
        if (op_e'(op_i) == OP_CLEAR) begin
          fill_q   <= '0;
          ctrl_x_q <= '{default: '0};
          ctrl_y_q <= '{default: '0};
        end else if (fill_q != 2'd3) begin
          ctrl_x_q[fill_q] <= point_x_i;
          ctrl_y_q[fill_q] <= point_y_i;
          fill_q           <= fill_q + 2'd1;
        end
      end
      if (state_q == ST_COEF) begin
        ctrl_x_q <= '{p3x_q, '0, '0};
        ctrl_y_q <= '{p3y_q, '0, '0};
        fill_q   <= 2'd1;
        k_q      <= '0;
        t_q      <= '0;
        phase_q  <= PH_H2;
        axis_q   <= 1'b0;
        end_q    <= (step_count_q == '0);
      end
      if (ctl.mul_en) begin
        phase_q <= phase_e'(phase_q + 2'd1);
        if (phase_q == PH_RND) begin
          axis_q <= ~axis_q;
        end
      end
      if (ctl.push) begin
        out_valid_q <= 1'b1;
        if (!end_q) begin
          k_q   <= k_q + StepW'(1);
          t_q   <= (t_sum > {1'b0, TMax}) ? TMax : t_sum[TW-1:0];
          end_q <= last_point;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.seg_start) begin
      p3x_q <= point_x_i;
      p3y_q <= point_y_i;
    end
    if (state_q == ST_COEF) begin
      coef_q[0] <= calc_coef(ctrl_x_q[0], ctrl_x_q[1], ctrl_x_q[2], p3x_q);
      coef_q[1] <= calc_coef(ctrl_y_q[0], ctrl_y_q[1], ctrl_y_q[2], p3y_q);
    end
    if (ctl.mul_en) begin
      h_q <= h_d;
      if (phase_q == PH_RND) begin
        if (axis_q) begin
          ry_q <= rnd_val;
        end else begin
          rx_q <= rnd_val;
        end
      end
    end
    if (ctl.push) begin
      out_x_q   <= end_q ? p3x_q : rx_q;
      out_y_q   <= end_q ? p3y_q : ry_q;
      out_end_q <= end_q;
    end
  end

  assign in_ready_o    = ctl.in_ready;
  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign is_endpoint_o = out_end_q;
  assign last_o        = out_end_q;

  `CBF_ASSERT_IMP(a_chain_tail_empty, fill_q <= 2'd1,
    ctrl_x_q[1] == '0 && ctrl_x_q[2] == '0 && ctrl_y_q[1] == '0 && ctrl_y_q[2] == '0,
    "Unfilled chain entries are not zero.")
  `CBF_ASSERT_IMP(a_k_bound, state_q != ST_IDLE && state_q != ST_COEF,
    k_q <= step_count_q, "Point counter ran past the step count.")
  `CBF_ASSERT_NXT(a_seg_start, ctl.seg_start, state_q == ST_COEF,
    "A closing point did not start a run.")
  `CBF_ASSERT_NXT(a_end_idle, ctl.push && end_q, state_q == ST_IDLE && out_valid_q,
    "The endpoint item did not end the run.")

endmodule
